### src/fvdt_pkg.sv
package fvdt_pkg;

	localparam int CFG_W       = 7;
	localparam int MAX_LEN_DEF = 64;
	localparam int TOK_DEPTH   = 4;
	localparam int RES_DEPTH   = 2;

	localparam logic [CFG_W-1:0] MAX_LEN_RST = 7'd32;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PCT,
		PH_DIGIT
	} phase_t;

	typedef enum logic [1:0] {
		BS_TAKE,
		BS_FLUSH,
		BS_BYTE
	} back_state_t;

	typedef enum logic {
		TK_FEED,
		TK_END
	} tok_kind_t;

	// One decoded byte for the sanitizer, or the marker that closes the tokens of one input byte.
	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] data;
		logic       last;
	} token_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       no_char;
	} result_t;

	function automatic logic hex_ok(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	// Letters carry their value minus nine in the low nibble.
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return c[6] ? (c[3:0] + 4'd9) : c[3:0];
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return c inside {CH_SPACE, [8'h09:8'h0D]};
	endfunction

	function automatic token_t feed_tok(input logic [7:0] c);
		token_t t;
		t.kind = TK_FEED;
		t.data = c;
		t.last = 1'b0;
		return t;
	endfunction

endpackage

### src/fvdt_fifo.sv
module fvdt_fifo #(
	parameter int W     = 10,
	parameter int DEPTH = fvdt_pkg::RES_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CTW = $clog2(DEPTH + 1);

	logic [W-1:0]   mem_q [0:DEPTH-1];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [CTW-1:0] cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CTW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CTW'(1);
			end
		end
	end

endmodule

### src/fvdt_front.sv
module fvdt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        in_char,
	input  logic              in_last,
	output logic              full,
	output logic              tok_push,
	output fvdt_pkg::token_t  tok_data,
	input  logic              tok_full
);

	fvdt_pkg::phase_t phase_q;
	fvdt_pkg::phase_t mid_phase;
	fvdt_pkg::phase_t phase_d;
	logic [7:0]       held_q;
	logic [7:0]       mid_held;
	logic [7:0]       held_d;

	fvdt_pkg::token_t slot_d [0:3];
	fvdt_pkg::token_t slot_q [0:3];
	logic [2:0]       n_d;
	logic [2:0]       cnt_q;
	logic [7:0]       plain;
	logic             is_pct;
	logic             c_hex;
	logic             adv;
	logic             take;

	assign is_pct = (in_char == fvdt_pkg::CH_PCT);
	assign c_hex  = fvdt_pkg::hex_ok(in_char);
	assign plain  = (in_char == fvdt_pkg::CH_PLUS) ? fvdt_pkg::CH_SPACE : in_char;

	// Escape state after this byte, before the end-of-value flush.
	always_comb begin
		mid_phase = fvdt_pkg::PH_IDLE;
		mid_held  = held_q;
		case (phase_q)
			fvdt_pkg::PH_IDLE: begin
				mid_phase = is_pct ? fvdt_pkg::PH_PCT : fvdt_pkg::PH_IDLE;
			end
			fvdt_pkg::PH_PCT: begin
				if (c_hex) begin
					mid_phase = fvdt_pkg::PH_DIGIT;
					mid_held  = in_char;
				end else begin
					mid_phase = is_pct ? fvdt_pkg::PH_PCT : fvdt_pkg::PH_IDLE;
				end
			end
			fvdt_pkg::PH_DIGIT: begin
				if (!c_hex && is_pct) begin
					mid_phase = fvdt_pkg::PH_PCT;
				end
			end
			default: begin
				mid_phase = fvdt_pkg::PH_IDLE;
			end
		endcase
		phase_d = in_last ? fvdt_pkg::PH_IDLE : mid_phase;
		held_d  = in_last ? 8'h00 : mid_held;
	end

	// Decoded bytes of this input byte in order, closed by an end marker.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			slot_d[i] = fvdt_pkg::feed_tok(8'h00);
		end
		n_d = 3'd0;
		case (phase_q)
			fvdt_pkg::PH_IDLE: begin
				if (!is_pct) begin
					slot_d[n_d[1:0]] = fvdt_pkg::feed_tok(plain);
					n_d = n_d + 3'd1;
				end
			end
			fvdt_pkg::PH_PCT: begin
				if (!c_hex) begin
					slot_d[n_d[1:0]] = fvdt_pkg::feed_tok(fvdt_pkg::CH_PCT);
					n_d = n_d + 3'd1;
					if (!is_pct) begin
						slot_d[n_d[1:0]] = fvdt_pkg::feed_tok(plain);
						n_d = n_d + 3'd1;
					end
				end
			end
			fvdt_pkg::PH_DIGIT: begin
				if (c_hex) begin
					slot_d[n_d[1:0]] = fvdt_pkg::feed_tok(
						{fvdt_pkg::hex_val(held_q), fvdt_pkg::hex_val(in_char)});
					n_d = n_d + 3'd1;
				end else begin
					slot_d[n_d[1:0]] = fvdt_pkg::feed_tok(fvdt_pkg::CH_PCT);
					n_d = n_d + 3'd1;
					slot_d[n_d[1:0]] = fvdt_pkg::feed_tok(held_q);
					n_d = n_d + 3'd1;
					if (!is_pct) begin
						slot_d[n_d[1:0]] = fvdt_pkg::feed_tok(plain);
						n_d = n_d + 3'd1;
					end
				end
			end
			default: begin
				n_d = 3'd0;
			end
		endcase
		// A dangling escape at the end of the value goes out as literal text.
		if (in_last && mid_phase != fvdt_pkg::PH_IDLE) begin
			slot_d[n_d[1:0]] = fvdt_pkg::feed_tok(fvdt_pkg::CH_PCT);
			n_d = n_d + 3'd1;
			if (mid_phase == fvdt_pkg::PH_DIGIT) begin
				slot_d[n_d[1:0]] = fvdt_pkg::feed_tok(mid_held);
				n_d = n_d + 3'd1;
			end
		end
		slot_d[n_d[1:0]].kind = fvdt_pkg::TK_END;
		slot_d[n_d[1:0]].last = in_last;
		n_d = n_d + 3'd1;
	end

	assign tok_push = (cnt_q != 3'd0);
	assign tok_data = slot_q[0];
	assign adv      = tok_push && !tok_full;
	assign full     = !((cnt_q == 3'd0) || (cnt_q == 3'd1 && adv));
	assign take     = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fvdt_pkg::PH_IDLE;
			held_q  <= 8'h00;
			cnt_q   <= 3'd0;
		end else if (take) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			cnt_q   <= n_d;
		end else if (adv) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			slot_q <= slot_d;
		end else if (adv) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
			slot_q[2] <= slot_q[3];
		end
	end

endmodule

### src/fvdt_back.sv
module fvdt_back #(
	parameter int MAX_LEN = fvdt_pkg::MAX_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [fvdt_pkg::CFG_W-1:0] max_len,
	input  fvdt_pkg::token_t           tok_data,
	input  logic                       tok_empty,
	output logic                       tok_pop,
	output logic                       res_push,
	output fvdt_pkg::result_t          res_data,
	input  logic                       res_full
);

	localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW    = $clog2(MAX_LEN + 1);
	localparam int LW    = (CW > fvdt_pkg::CFG_W) ? CW : fvdt_pkg::CFG_W;
	localparam int DEPTH = 1 << AW;

	fvdt_pkg::back_state_t state_q;
	fvdt_pkg::back_state_t state_d;

	logic [7:0]    mem [0:DEPTH-1];
	logic [7:0]    rdata_q;
	logic [AW-1:0] rd_addr;

	logic          seen_q;
	logic          ended_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] emit_q;
	logic [AW-1:0] idx_q;
	logic [7:0]    byte_q;
	logic          pend_v_q;
	logic [7:0]    pend_c_q;

	logic [7:0]    b;
	logic          go;
	logic          tok_ok;
	logic          b_ws;
	logic          b_crlf;
	logic          run_full;
	logic          run_empty;
	logic          flush_done;
	logic          emit_ok;

	logic          emit_v;
	logic [7:0]    emit_c;
	logic          emit_take;
	logic          end_v;
	logic          set_end;
	logic          run_wr;
	logic          run_clr;
	logic          mark_seen;
	logic          idx_inc;

	assign b          = tok_data.data;
	assign go         = !res_full;
	assign tok_ok     = !tok_empty;
	assign b_ws       = fvdt_pkg::is_ws(b);
	assign b_crlf     = (b == fvdt_pkg::CH_CR) || (b == fvdt_pkg::CH_LF);
	assign run_full   = (cnt_q == CW'(MAX_LEN));
	assign run_empty  = (cnt_q == '0);
	assign flush_done = ((CW'(idx_q) + CW'(1)) == cnt_q);
	assign emit_ok    = (LW'(emit_q) < LW'(max_len)) && (emit_q != CW'(MAX_LEN));
	assign emit_take  = emit_v && emit_ok;

	always_comb begin
		state_d = state_q;
		case (state_q)
			fvdt_pkg::BS_TAKE: begin
				if (go && tok_ok && tok_data.kind == fvdt_pkg::TK_FEED && !ended_q
						&& b != fvdt_pkg::CH_NUL && !b_ws && !run_empty) begin
					state_d = fvdt_pkg::BS_FLUSH;
				end
			end
			fvdt_pkg::BS_FLUSH: begin
				if (go && flush_done) begin
					state_d = fvdt_pkg::BS_BYTE;
				end
			end
			fvdt_pkg::BS_BYTE: begin
				if (go) begin
					state_d = fvdt_pkg::BS_TAKE;
				end
			end
			default: begin
				state_d = fvdt_pkg::BS_TAKE;
			end
		endcase
	end

	always_comb begin
		tok_pop   = 1'b0;
		emit_v    = 1'b0;
		emit_c    = b;
		end_v     = 1'b0;
		set_end   = 1'b0;
		run_wr    = 1'b0;
		run_clr   = 1'b0;
		mark_seen = 1'b0;
		idx_inc   = 1'b0;
		case (state_q)
			fvdt_pkg::BS_TAKE: begin
				if (go && tok_ok) begin
					tok_pop = 1'b1;
					if (tok_data.kind == fvdt_pkg::TK_END) begin
						end_v = 1'b1;
					end else if (!ended_q) begin
						if (b == fvdt_pkg::CH_NUL) begin
							set_end = 1'b1;
						end else if (b_ws) begin
							// Whitespace is held only once text has started.
							run_wr = !b_crlf && seen_q && !run_full;
						end else begin
							mark_seen = 1'b1;
							emit_v    = run_empty;
						end
					end
				end
			end
			fvdt_pkg::BS_FLUSH: begin
				if (go) begin
					emit_v  = 1'b1;
					emit_c  = rdata_q;
					idx_inc = 1'b1;
				end
			end
			fvdt_pkg::BS_BYTE: begin
				if (go) begin
					emit_v  = 1'b1;
					emit_c  = byte_q;
					run_clr = 1'b1;
				end
			end
			default: begin
				tok_pop = 1'b0;
			end
		endcase
	end

	// The newest emitted byte waits in a holding register so that the end of an
	// item can still mark it last.
	always_comb begin
		res_push         = 1'b0;
		res_data.ch      = pend_c_q;
		res_data.last    = 1'b0;
		res_data.no_char = 1'b0;
		if (end_v) begin
			res_push = tok_data.last || pend_v_q;
			if (tok_data.last) begin
				res_data.last = 1'b1;
				if (!pend_v_q) begin
					res_data.ch      = 8'h00;
					res_data.no_char = 1'b1;
				end
			end
		end else if (emit_take) begin
			res_push = pend_v_q;
		end
	end

	assign rd_addr = (state_q == fvdt_pkg::BS_FLUSH) ? (idx_q + AW'(1)) : '0;

	always_ff @(posedge clk) begin
		if (run_wr) begin
			mem[cnt_q[AW-1:0]] <= b;
		end
		if (go) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop) begin
			byte_q <= b;
		end
		if (emit_take) begin
			pend_c_q <= emit_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fvdt_pkg::BS_TAKE;
			seen_q   <= 1'b0;
			ended_q  <= 1'b0;
			cnt_q    <= '0;
			emit_q   <= '0;
			idx_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fvdt_pkg::BS_TAKE) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
			if (end_v) begin
				pend_v_q <= 1'b0;
			end else if (emit_take) begin
				pend_v_q <= 1'b1;
			end
			if (end_v && tok_data.last) begin
				seen_q  <= 1'b0;
				ended_q <= 1'b0;
				cnt_q   <= '0;
				emit_q  <= '0;
			end else begin
				if (set_end) begin
					ended_q <= 1'b1;
				end
				if (mark_seen) begin
					seen_q <= 1'b1;
				end
				if (run_wr) begin
					cnt_q <= cnt_q + CW'(1);
				end else if (run_clr) begin
					cnt_q <= '0;
				end
				if (emit_take) begin
					emit_q <= emit_q + CW'(1);
				end
			end
		end
	end

endmodule

### src/form_value_decode_trim.sv
// Channel  Handshake            Payload
// input    push / full          in_char, in_last
// result   empty / pop          out_char, out_last, no_char
// config   cfg_valid/cfg_ready  cfg_data (max_len)
//
// The front decodes one byte per transfer into one to four tokens and takes the next
// byte in the cycle its final token enters the token queue.
// The back takes tokens one at a time; a byte that ends a held whitespace run first
// replays the run through the single run buffer read port and then goes out itself.
// arst_n clears all control state at once; the run buffer needs no clearing pass.
// A full result queue stalls the back; a full token queue stalls the front.
module form_value_decode_trim #(
	parameter int MAX_LEN = fvdt_pkg::MAX_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [7:0]                 in_char,
	input  logic                       in_last,
	output logic                       empty,
	input  logic                       pop,
	output logic [7:0]                 out_char,
	output logic                       out_last,
	output logic                       no_char,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [fvdt_pkg::CFG_W-1:0] cfg_data
);

	localparam int TW = $bits(fvdt_pkg::token_t);
	localparam int RW = $bits(fvdt_pkg::result_t);

	logic [fvdt_pkg::CFG_W-1:0] max_len_q;

	logic              ftok_push;
	fvdt_pkg::token_t  ftok_data;
	logic              ftok_full;
	logic [TW-1:0]     qtok_raw;
	fvdt_pkg::token_t  qtok_data;
	logic              qtok_empty;
	logic              qtok_pop;

	logic              res_push;
	fvdt_pkg::result_t res_data;
	logic              res_full;
	logic [RW-1:0]     res_raw;
	fvdt_pkg::result_t res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= fvdt_pkg::MAX_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	fvdt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_char  (in_char),
		.in_last  (in_last),
		.full     (full),
		.tok_push (ftok_push),
		.tok_data (ftok_data),
		.tok_full (ftok_full)
	);

	fvdt_fifo #(
		.W     (TW),
		.DEPTH (fvdt_pkg::TOK_DEPTH)
	) u_tok_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ftok_push),
		.wdata  (ftok_data),
		.full   (ftok_full),
		.pop    (qtok_pop),
		.rdata  (qtok_raw),
		.empty  (qtok_empty)
	);

	assign qtok_data = fvdt_pkg::token_t'(qtok_raw);

	fvdt_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_len   (max_len_q),
		.tok_data  (qtok_data),
		.tok_empty (qtok_empty),
		.tok_pop   (qtok_pop),
		.res_push  (res_push),
		.res_data  (res_data),
		.res_full  (res_full)
	);

	fvdt_fifo #(
		.W     (RW),
		.DEPTH (fvdt_pkg::RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_raw),
		.empty  (empty)
	);

	assign res_out  = fvdt_pkg::result_t'(res_raw);
	assign out_char = res_out.ch;
	assign out_last = res_out.last;
	assign no_char  = res_out.no_char;

endmodule
